/* src/shared_buffer_multi_stack_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shared buffer multi-stack block
// Concurrent checks clocked on clk_i, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef SHARED_BUFFER_MULTI_STACK_TOP_MACROS_SVH
`define SHARED_BUFFER_MULTI_STACK_TOP_MACROS_SVH

// Check a property outside of reset.
`define SBMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property at every edge, reset included.
`define SBMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/sbms_pkg.sv */
// ----------------------------------------------------------------------------
// sbms_pkg
// Types and sizes shared by the multi-stack block, its store and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbms_pkg;

  localparam int NUM_STACKS = 8;
  localparam int CAPACITY   = 64;
  localparam int SID_W      = 3;
  localparam int VAL_W      = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int PTR_W      = $clog2(CAPACITY + 1);

  typedef logic [PTR_W-1:0] ptr_t;

  // A pointer equal to the capacity marks "no entry"
  localparam ptr_t NO_ENTRY = PTR_W'(CAPACITY);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [SID_W-1:0]        stack_id;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] pop_value;
  } out_item_t;

  // Write request into the entry store
  typedef struct packed {
    logic                    en;
    logic [ADDR_W-1:0]       addr;
    logic                    wr_value;
    logic signed [VAL_W-1:0] value;
    ptr_t                    link;
  } store_wr_t;

endpackage

/* src/shared_buffer_multi_stack_top.sv */
// ----------------------------------------------------------------------------
// shared_buffer_multi_stack_top
// Eight LIFO stacks sharing one 64-entry store through a linked free list.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one item per push or
// pop, with the stack number and, for a push, the value.
// Output channel (out_valid_o / out_stall_i / out_item_o): one item per
// input item with an ok flag and, for a successful pop, the popped value.
// A push fails (ok low) when the store is full, a pop when the stack is
// empty; neither changes any state then.
// Sequence: the entry store is read at the input accept; in the EXEC state the
// pointer and link write-back follows and the result is registered. The block
// takes no new item until that write-back is done.
// The finished item sits in the output register; while a stall holds it
// there the input stalls too, and the next item is taken at the edge that
// frees the output register.
// Reset: all stacks empty, free list runs through entries 0 to 63 in order,
// output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shared_buffer_multi_stack_top
  import sbms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e    state_q;
  in_item_t  req_q;
  ptr_t      entry_q;
  ptr_t      tops_q [NUM_STACKS];
  ptr_t      free_head_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic                    in_acc;
  ptr_t                    entry_sel;
  logic                    rd_en;
  logic                    hit;
  store_wr_t               wr;
  ptr_t                    link_rd;
  logic signed [VAL_W-1:0] value_rd;

  // Take an item when idle and the output register frees up
  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Pick the entry: free head for a push, stack top for a pop
  assign entry_sel = (in_item_i.op == OP_POP) ? tops_q[in_item_i.stack_id] : free_head_q;
  assign rd_en     = in_acc && (entry_sel < NO_ENTRY);
  assign hit       = entry_q < NO_ENTRY;

  // Write back the touched entry
  always_comb begin
    wr.en       = (state_q == ST_EXEC) && hit;
    wr.addr     = entry_q[ADDR_W-1:0];
    wr.wr_value = (req_q.op == OP_PUSH);
    wr.value    = req_q.push_value;
    wr.link     = (req_q.op == OP_PUSH) ? tops_q[req_q.stack_id] : free_head_q;
  end

  sbms_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (entry_sel[ADDR_W-1:0]),
    .wr_i      (wr),
    .link_o    (link_rd),
    .value_o   (value_rd)
  );

  // Sequence the item, update pointers, hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      entry_q     <= NO_ENTRY;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_q[i] <= NO_ENTRY;
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            req_q   <= in_item_i;
            entry_q <= entry_sel;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (hit) begin
            if (req_q.op == OP_PUSH) begin
              free_head_q            <= link_rd;
              tops_q[req_q.stack_id] <= entry_q;
            end else begin
              tops_q[req_q.stack_id] <= link_rd;
              free_head_q            <= entry_q;
            end
          end
          out_item_q.ok        <= hit;
          out_item_q.pop_value <= (hit && (req_q.op == OP_POP)) ? value_rd : '0;
          out_valid_q          <= 1'b1;
          state_q              <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* src/sbms_store.sv */
// ----------------------------------------------------------------------------
// sbms_store
// Entry store: value memory and link memory, one read and one write a cycle,
// read data registered. Links never written read as "next entry".
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbms_store
  import sbms_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [ADDR_W-1:0]       rd_addr_i,
  input  store_wr_t               wr_i,
  output ptr_t                    link_o,
  output logic signed [VAL_W-1:0] value_o
);

  logic signed [VAL_W-1:0] value_mem [CAPACITY];
  ptr_t                    link_mem  [CAPACITY];

  logic [CAPACITY-1:0]     link_vld_q;
  logic                    rd_vld_q;
  logic [ADDR_W-1:0]       rd_addr_q;
  ptr_t                    link_rd_q;
  logic signed [VAL_W-1:0] value_rd_q;

  // Write and read the memories
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      link_mem[wr_i.addr] <= wr_i.link;
      if (wr_i.wr_value) begin
        value_mem[wr_i.addr] <= wr_i.value;
      end
    end
    if (rd_en_i) begin
      link_rd_q  <= link_mem[rd_addr_i];
      value_rd_q <= value_mem[rd_addr_i];
    end
  end

  // Track which links hold written data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (wr_i.en) begin
        link_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= link_vld_q[rd_addr_i];
        rd_addr_q <= rd_addr_i;
      end
    end
  end

  // Fall back to the reset chain for unwritten links
  assign link_o  = rd_vld_q ? link_rd_q : (PTR_W'(rd_addr_q) + PTR_W'(1));
  assign value_o = value_rd_q;

endmodule

/* src/sbms_checker.sv */
// ----------------------------------------------------------------------------
// sbms_checker
// Port-level checks for the multi-stack block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shared_buffer_multi_stack_top_macros.svh"

module sbms_checker
  import sbms_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // A held result keeps its payload
  `SBMS_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)), "output item changed while stalled")

  // Output register is empty while in reset
  `SBMS_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

  // One item at a time: no accept right after an accept
  `SBMS_ASSERT(a_no_b2b, in_acc |=> in_stall_o, "input accepted in back-to-back cycles")

  // An accepted push is followed by a valid result; a push never returns a value
  `SBMS_ASSERT(a_latency, (in_acc && (in_item_i.op == OP_PUSH)) |-> ##2 (out_valid_o && (out_item_o.pop_value == '0)), "push result missing or carries a value")

  // A failed item returns zero
  `SBMS_ASSERT(a_fail_zero, (out_valid_o && !out_item_o.ok) |-> (out_item_o.pop_value == '0), "failed item carries a value")

endmodule

bind shared_buffer_multi_stack_top sbms_checker u_sbms_checker (.*);
